// ===== design/cptq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cptq_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int LEVELS_DEF = 4;

  typedef enum logic [1:0] {
    OP_POST   = 2'd0,
    OP_CANCEL = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  priority_req;
    logic        has_key;
    logic [7:0]  key;
    logic [15:0] task_handle;
    logic [31:0] target_id;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] result_id;
    logic [15:0] result_handle;
    logic [1:0]  result_priority;
    logic        overflow;
    logic [4:0]  task_count;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_SCAN2,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic pass2_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic need_pass2;
    logic need_scan;
  } stat_t;
endpackage
`default_nettype wire

// ===== design/cptq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cptq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire cptq_pkg::stat_t  stat,
  output cptq_pkg::cmd_t        cmd
);
  cptq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= cptq_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      cptq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = cptq_pkg::ST_SCAN1;
        end
      end
      cptq_pkg::ST_SCAN1: begin
        if (!stat.need_scan) state_next = cptq_pkg::ST_FINISH;
        else begin
          cmd.scan_step = 1'b1;
          if (stat.scan_last) begin
            if (stat.need_pass2) begin
              cmd.pass2_start = 1'b1;
              state_next = cptq_pkg::ST_SCAN2;
            end else state_next = cptq_pkg::ST_FINISH;
          end
        end
      end
      cptq_pkg::ST_SCAN2: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = cptq_pkg::ST_FINISH;
      end
      cptq_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = cptq_pkg::ST_OUT;
      end
      cptq_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = cptq_pkg::ST_IDLE;
      end
      default: state_next = cptq_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/cptq_data.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cptq_data #(
  parameter int SLOTS  = cptq_pkg::SLOTS_DEF,
  parameter int LEVELS = cptq_pkg::LEVELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cptq_pkg::in_word_t in_word,
  input  wire cptq_pkg::cmd_t     cmd,
  output cptq_pkg::stat_t         stat,
  output cptq_pkg::out_word_t     out_word
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [SLOTS-1:0] valid;
  logic [31:0]      s_id    [SLOTS];
  logic [LW-1:0]    s_lvl   [SLOTS];
  logic             s_keyed [SLOTS];
  logic [7:0]       s_key   [SLOTS];
  logic [15:0]      s_hdl   [SLOTS];
  logic [31:0]      s_ord   [SLOTS];

  logic [31:0] id_counter, order_counter;
  logic [CW-1:0] live_count;
  cptq_pkg::in_word_t req;
  logic [LW-1:0] lvl_req;
  logic [IW-1:0] idx;
  logic pass2;
  logic hit;
  logic [IW-1:0] hit_idx;
  logic free_found;
  logic [IW-1:0] free_idx;
  logic [LW-1:0] best_lvl;
  logic [31:0] best_age;
  cptq_pkg::out_word_t res;

  logic [31:0] age;
  logic is_post, is_cancel, is_pop;
  assign age = order_counter - s_ord[idx];
  assign is_post   = req.opcode == cptq_pkg::OP_POST;
  assign is_cancel = req.opcode == cptq_pkg::OP_CANCEL;
  assign is_pop    = req.opcode == cptq_pkg::OP_POP;

  assign stat.scan_last  = idx == IW'(SLOTS - 1);
  assign stat.need_pass2 = is_post && req.has_key;
  assign stat.need_scan  = (is_post && req.task_handle != 16'd0) ||
                           (is_cancel && req.target_id != 32'd0) || is_pop;
  assign out_word = res;

  // pass 1 of a keyed post finds the key; pass 2 the free slot (after the drop)
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      id_counter <= 32'd1;
      order_counter <= 32'd0;
      live_count <= '0;
    end else begin
      if (cmd.load) begin
        req <= in_word;
        lvl_req <= (32'(in_word.priority_req) >= 32'(LEVELS)) ? LW'(LEVELS - 1)
                                                              : LW'(in_word.priority_req);
        idx <= '0;
        pass2 <= 1'b0;
        hit <= 1'b0;
        hit_idx <= '0;
        free_found <= 1'b0;
        free_idx <= '0;
      end
      if (cmd.scan_step) begin
        idx <= idx + IW'(1);
        if (is_post && req.has_key && !pass2) begin
          if (!hit && valid[idx] && s_keyed[idx] && s_key[idx] == req.key) begin
            hit <= 1'b1;
            hit_idx <= idx;
          end
        end else if (is_post) begin
          if (!free_found && !valid[idx]) begin
            free_found <= 1'b1;
            free_idx <= idx;
          end
        end else if (is_cancel) begin
          if (!hit && valid[idx] && s_id[idx] == req.target_id) begin
            hit <= 1'b1;
            hit_idx <= idx;
          end
        end else if (valid[idx]) begin
          if (!hit || s_lvl[idx] < best_lvl || (s_lvl[idx] == best_lvl && age > best_age))
          begin
            hit <= 1'b1;
            hit_idx <= idx;
            best_lvl <= s_lvl[idx];
            best_age <= age;
          end
        end
      end
      if (cmd.pass2_start) begin
        idx <= '0;
        pass2 <= 1'b1;
        if (hit || (valid[idx] && s_keyed[idx] && s_key[idx] == req.key)) begin
          valid[hit ? hit_idx : idx] <= 1'b0;
          live_count <= live_count - CW'(1);
        end
      end
      if (cmd.finish) begin
        res <= '0;
        res.task_count <= 5'(live_count);
        case (req.opcode)
          cptq_pkg::OP_POST: begin
            if (req.task_handle != 16'd0) begin
              if (!free_found) res.overflow <= 1'b1;
              else begin
                valid[free_idx] <= 1'b1;
                s_id[free_idx] <= id_counter;
                s_lvl[free_idx] <= lvl_req;
                s_keyed[free_idx] <= req.has_key;
                s_key[free_idx] <= req.key;
                s_hdl[free_idx] <= req.task_handle;
                s_ord[free_idx] <= order_counter;
                live_count <= live_count + CW'(1);
                res.task_count <= 5'(live_count + CW'(1));
                res.ok <= 1'b1;
                res.result_id <= id_counter;
                id_counter <= (id_counter == 32'hFFFF_FFFF) ? 32'd1 : id_counter + 32'd1;
                order_counter <= order_counter + 32'd1;
              end
            end
          end
          cptq_pkg::OP_CLEAR: begin
            valid <= '0;
            live_count <= '0;
            res.task_count <= 5'd0;
            res.ok <= 1'b1;
          end
          default: begin
            if (hit) begin
              valid[hit_idx] <= 1'b0;
              live_count <= live_count - CW'(1);
              res.task_count <= 5'(live_count - CW'(1));
              res.ok <= 1'b1;
              if (is_pop) begin
                res.result_id <= s_id[hit_idx];
                res.result_handle <= s_hdl[hit_idx];
                res.result_priority <= 2'(s_lvl[hit_idx]);
              end
            end
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/coalescing_priority_task_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Input accept to result valid: cancel, pop and unkeyed post scan every slot once;
// a keyed post scans twice (key scan, then free-slot scan); clear, null post and
// cancel of id 0 skip the scan and go straight to the commit state.
// Throughput: one word at a time; the next word is taken only after the result
// has been taken. The scan examines one slot per cycle.
// Reset: synchronous; empties all slots, id counter to 1, order counter to 0.
module coalescing_priority_task_queue_top #(
  parameter int SLOTS  = cptq_pkg::SLOTS_DEF,
  parameter int LEVELS = cptq_pkg::LEVELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cptq_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cptq_pkg::out_word_t      out_data
);
  cptq_pkg::cmd_t  cmd;
  cptq_pkg::stat_t stat;

  // sequencer: accept, scan, commit, hold result until taken
  cptq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  // slot store and scan datapath
  cptq_data #(.SLOTS(SLOTS), .LEVELS(LEVELS)) u_data (
    .clk, .rst, .in_word(in_data), .cmd, .stat, .out_word(out_data)
  );
endmodule
`default_nettype wire
